// ===== hw/rtl/frame_destuff_checksum_check_macros.svh =====
// assertion helpers shared by the front, queue and back rtl files
`ifndef FRAME_DESTUFF_CHECKSUM_CHECK_MACROS_SVH
`define FRAME_DESTUFF_CHECKSUM_CHECK_MACROS_SVH

// same-cycle implication
`define FDC_ASSERT_NOW(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("fdc assertion failed");

// next-cycle implication
`define FDC_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("fdc assertion failed");

`endif

// ===== hw/rtl/fdc_pkg.sv =====
`timescale 1ns / 1ps

package fdc_pkg;

    localparam logic [7:0] ESC_BYTE    = 8'h7D;
    localparam logic [7:0] ESC_OF_ESC  = 8'h5D;
    localparam logic [7:0] ESC_OF_FLAG = 8'h5E;
    localparam logic [7:0] FLAG_BYTE   = 8'h7E;
    localparam logic [7:0] CHECK_BASE  = 8'hFF;

    localparam logic [2:0] SHORT_LIMIT = 3'd3;
    localparam logic [2:0] SUM_START   = 3'd3;
    localparam logic [2:0] HIGH_INDEX  = 3'd4;
    localparam logic [2:0] LOW_INDEX   = 3'd5;
    localparam logic [2:0] SPEED_COUNT = 3'd6;
    localparam logic [2:0] COUNT_MAX   = 3'd7;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0] raw_byte;
        logic       frame_end;
    } frame_beat_t;

    typedef struct packed {
        logic        check_ok;
        logic [7:0]  received_check;
        logic [7:0]  computed_check;
        logic [11:0] speed_value;
        logic        speed_present;
        logic        short_frame;
    } check_beat_t;

    // up to two decoded bytes per raw byte
    typedef struct packed {
        logic       first_valid;
        logic       second_valid;
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic       last;
    } fdc_work_t;

    typedef struct packed {
        logic [2:0] count;
        logic [7:0] newest;
        logic [7:0] older;
        logic [7:0] sum;
        logic [7:0] speed_high;
        logic [3:0] speed_low;
    } fdc_acc_t;

    function automatic fdc_acc_t take_byte(input fdc_acc_t s, input logic [7:0] b);
        fdc_acc_t r;
        r = s;
        if (s.count >= SUM_START)
        begin
            r.sum = s.sum + s.older;
        end
        r.older  = s.newest;
        r.newest = b;
        if (s.count == HIGH_INDEX)
        begin
            r.speed_high = b;
        end
        if (s.count == LOW_INDEX)
        begin
            r.speed_low = b[7:4];
        end
        if (s.count != COUNT_MAX)
        begin
            r.count = s.count + 3'd1;
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/fdc_front.sv =====
`timescale 1ns / 1ps
`include "frame_destuff_checksum_check_macros.svh"

module fdc_front
    import fdc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        frame_valid,
    output logic        frame_stall,
    input  frame_beat_t frame_beat,
    input  logic        queue_full,
    output logic        push,
    output fdc_work_t   work
);

    logic pending_reg;
    logic pending_next;
    logic accept;
    logic [7:0] b;
    logic last;

    assign frame_stall = queue_full;
    assign accept      = frame_valid && !queue_full;
    assign b           = frame_beat.raw_byte;
    assign last        = frame_beat.frame_end;

    always_comb
    begin
        work              = '0;
        work.last         = last;
        work.second_byte  = b;
        pending_next      = 1'b0;
        if (pending_reg)
        begin
            work.first_valid = 1'b1;
            if (b == ESC_OF_ESC)
            begin
                work.first_byte = ESC_BYTE;
            end
            else if (b == ESC_OF_FLAG)
            begin
                work.first_byte = FLAG_BYTE;
            end
            else
            begin
                work.first_byte = ESC_BYTE;
                if (b == ESC_BYTE && !last)
                begin
                    pending_next = 1'b1;
                end
                else
                begin
                    work.second_valid = 1'b1;
                end
            end
        end
        else if (b == ESC_BYTE && !last)
        begin
            pending_next = 1'b1;
        end
        else
        begin
            work.first_valid = 1'b1;
            work.first_byte  = b;
        end
    end

    // a lone escape opener carries nothing forward
    assign push = accept && (work.first_valid || last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
        end
        else if (accept)
        begin
            pending_reg <= pending_next;
        end
    end

    `FDC_ASSERT_NEXT(a_pending_clear_after_end, clk, rst_n, accept && last, !pending_reg)
    `FDC_ASSERT_NOW(a_end_always_pushes, clk, rst_n, accept && last, push && work.first_valid)

endmodule

// ===== hw/rtl/fdc_queue.sv =====
`timescale 1ns / 1ps
`include "frame_destuff_checksum_check_macros.svh"

module fdc_queue
    import fdc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  fdc_work_t push_work,
    output logic      full,
    input  logic      pop,
    output logic      avail,
    output fdc_work_t head
);

    fdc_work_t             entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg;
    logic [QUEUE_AW-1:0]   rd_ptr_reg;
    logic [QUEUE_CW-1:0]   count_reg;
    logic [QUEUE_CW-1:0]   count_next;

    assign full  = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign avail = (count_reg != '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QUEUE_CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QUEUE_CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_work;
        end
    end

    `FDC_ASSERT_NOW(a_no_push_when_full, clk, rst_n, full, !push)
    `FDC_ASSERT_NOW(a_no_pop_when_empty, clk, rst_n, !avail, !pop)

endmodule

// ===== hw/rtl/fdc_back.sv =====
`timescale 1ns / 1ps
`include "frame_destuff_checksum_check_macros.svh"

module fdc_back
    import fdc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        avail,
    input  fdc_work_t   head,
    output logic        pop,
    output logic        check_valid,
    input  logic        check_stall,
    output check_beat_t check_beat
);

    fdc_acc_t    acc_reg;
    fdc_acc_t    acc_next;
    fdc_acc_t    after_first;
    fdc_acc_t    after_second;
    logic        valid_reg;
    logic        valid_next;
    check_beat_t result_reg;
    check_beat_t result_next;
    logic        is_short;
    logic        has_speed;

    // only a frame end needs the output register
    assign pop = avail && (!head.last || !valid_reg || !check_stall);

    always_comb
    begin
        after_first  = head.first_valid ? take_byte(acc_reg, head.first_byte) : acc_reg;
        after_second = head.second_valid ? take_byte(after_first, head.second_byte)
                                         : after_first;
        is_short     = (after_second.count < SHORT_LIMIT);
        has_speed    = (after_second.count >= SPEED_COUNT);

        result_next = '0;
        result_next.short_frame = is_short;
        if (!is_short)
        begin
            result_next.received_check = after_second.older;
            result_next.computed_check = CHECK_BASE - after_second.sum;
            result_next.check_ok       = (after_second.older == (CHECK_BASE - after_second.sum));
        end
        if (has_speed)
        begin
            result_next.speed_present = 1'b1;
            result_next.speed_value   = {after_second.speed_high, after_second.speed_low};
        end

        acc_next = acc_reg;
        if (pop)
        begin
            acc_next = head.last ? fdc_acc_t'('0) : after_second;
        end

        valid_next = valid_reg && check_stall;
        if (pop && head.last)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg   <= acc_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && head.last)
        begin
            result_reg <= result_next;
        end
    end

    assign check_valid = valid_reg;
    assign check_beat  = result_reg;

    `FDC_ASSERT_NEXT(a_result_after_end, clk, rst_n, pop && head.last, valid_reg)
    `FDC_ASSERT_NOW(a_short_zero_check, clk, rst_n, valid_reg && result_reg.short_frame,
                    !result_reg.check_ok && result_reg.computed_check == '0)

endmodule

// ===== hw/rtl/frame_destuff_checksum_check.sv =====
// frame destuffer and additive check byte verifier
// frame channel: frame_valid / frame_stall / frame_beat, one raw byte per beat,
//   flag bytes included, frame_end set on the last byte of a frame
// check channel: check_valid / check_stall / check_beat, one beat per frame
//   carrying the check result, the check bytes and the 12-bit speed field
// throughput: one raw byte per cycle while frame_stall is low; the front
//   destuffs a byte in the cycle it is taken, the back absorbs up to two
//   decoded bytes per cycle unless a frame end waits on a stalled result
// check_valid rises once the queue entry of the frame's last byte and then the
//   output register are written; a stalled earlier result holds that entry back
// a stalled result holds in the output register; bytes of the next frame keep
//   flowing into the back until its last byte reaches the queue head, after
//   which the queue fills and frame_stall rises
// reset clears the escape flag, the running sums, the queue and any pending
//   result; the block takes bytes in the first cycle after reset
`timescale 1ns / 1ps

module frame_destuff_checksum_check
    import fdc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        frame_valid,
    output logic        frame_stall,
    input  frame_beat_t frame_beat,
    output logic        check_valid,
    input  logic        check_stall,
    output check_beat_t check_beat
);

    logic      push;
    logic      pop;
    logic      full;
    logic      avail;
    fdc_work_t push_work;
    fdc_work_t head;

    fdc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (frame_valid),
        .frame_stall (frame_stall),
        .frame_beat  (frame_beat),
        .queue_full  (full),
        .push        (push),
        .work        (push_work)
    );

    fdc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_work (push_work),
        .full      (full),
        .pop       (pop),
        .avail     (avail),
        .head      (head)
    );

    fdc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .avail       (avail),
        .head        (head),
        .pop         (pop),
        .check_valid (check_valid),
        .check_stall (check_stall),
        .check_beat  (check_beat)
    );

endmodule
